[rtl/ubsd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ubsd_pkg
// Types, constants and decode functions shared by the BOM-sniffing decoder.
// ----------------------------------------------------------------------------
package ubsd_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_word_t;

	typedef struct packed {
		logic [31:0] code_point;
		logic        has_char;
		logic [1:0]  status;
		logic        out_last;
	} out_word_t;

	typedef enum logic [2:0] {
		MODE_SNIFF = 3'd0,
		MODE_UTF8  = 3'd1,
		MODE_UTF16 = 3'd2,
		MODE_UTF32 = 3'd3,
		MODE_UNSUP = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		DEC_WAIT    = 3'd0,
		DEC_REPLAY8 = 3'd1,
		DEC_SKIP8   = 3'd2,
		DEC_UTF16   = 3'd3,
		DEC_UTF32   = 3'd4,
		DEC_UNSUP   = 3'd5
	} dec_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_UNSUP = 2'd1;
	localparam logic [1:0] ST_TRUNC = 2'd2;

	localparam int MAX_RES    = 4;
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic [7:0] BYTE_ZERO = 8'h00;
	localparam logic [7:0] BOM_EF    = 8'hEF;
	localparam logic [7:0] BOM_BB    = 8'hBB;
	localparam logic [7:0] BOM_BF    = 8'hBF;
	localparam logic [7:0] BOM_FE    = 8'hFE;
	localparam logic [7:0] BOM_FF    = 8'hFF;

	localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
	localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
	localparam logic [7:0] UTF8_LEAD4 = 8'hF0;

	localparam logic [15:0] SUR_MASK = 16'hFC00;
	localparam logic [15:0] SUR_HIGH = 16'hD800;
	localparam logic [31:0] SUP_BASE = 32'h0001_0000;

	// decoder state carried from byte to byte
	typedef struct packed {
		logic [31:0] acc;
		logic [1:0]  pend;
		logic [9:0]  hi;
		logic        held;
	} dstate_t;

	typedef struct packed {
		dstate_t     st;
		logic        emit;
		logic [31:0] cp;
	} feed_t;

	function automatic dec_t decide(
		input logic [7:0] b0,
		input logic [7:0] b1,
		input logic [7:0] b2,
		input logic [7:0] b3,
		input logic [2:0] c,
		input logic       last
	);
		dec_t d;
		d = last ? DEC_REPLAY8 : DEC_WAIT;
		case (b0)
			BOM_EF: begin
				if (c >= 3'd2 && b1 != BOM_BB)
					d = DEC_REPLAY8;
				else if (c >= 3'd3)
					d = (b2 == BOM_BF) ? DEC_SKIP8 : DEC_REPLAY8;
			end
			BOM_FE: begin
				if (c >= 3'd2)
					d = (b1 == BOM_FF) ? DEC_UNSUP : DEC_REPLAY8;
			end
			BOM_FF: begin
				if (c >= 3'd2 && b1 != BOM_FE)
					d = DEC_REPLAY8;
				else if (c >= 3'd4)
					d = (b2 == BYTE_ZERO && b3 == BYTE_ZERO) ? DEC_UTF32 : DEC_UTF16;
				else if (c >= 3'd3 && b2 != BYTE_ZERO)
					d = DEC_UTF16;
				else if (c >= 3'd2 && last)
					d = DEC_UTF16;
			end
			BYTE_ZERO: begin
				if (c >= 3'd2 && b1 != BYTE_ZERO)
					d = DEC_REPLAY8;
				else if (c >= 3'd3 && b2 != BOM_FE)
					d = DEC_REPLAY8;
				else if (c >= 3'd4)
					d = (b3 == BOM_FF) ? DEC_UNSUP : DEC_REPLAY8;
			end
			default: d = DEC_REPLAY8;
		endcase
		return d;
	endfunction

	// one byte through the decoder of the given mode
	function automatic feed_t feed(
		input mode_t      mode,
		input dstate_t    s,
		input logic [7:0] b
	);
		feed_t       r;
		logic [15:0] u;
		logic [31:0] pair;
		logic [31:0] w32;
		logic [31:0] w8;
		r      = '0;
		r.st   = s;
		u      = {b, s.acc[7:0]};
		pair   = SUP_BASE + {12'd0, s.hi, u[9:0]};
		w32    = s.acc | ({24'd0, b} << {s.pend, 3'b000});
		w8     = {s.acc[25:0], b[5:0]};
		case (mode)
			MODE_UTF8: begin
				if (s.pend == 2'd0) begin
					if (b < UTF8_LEAD2) begin
						r.emit = 1'b1;
						r.cp   = {24'd0, b};
					end else if (b < UTF8_LEAD3) begin
						r.st.acc  = {27'd0, b[4:0]};
						r.st.pend = 2'd1;
					end else if (b < UTF8_LEAD4) begin
						r.st.acc  = {28'd0, b[3:0]};
						r.st.pend = 2'd2;
					end else begin
						r.st.acc  = {29'd0, b[2:0]};
						r.st.pend = 2'd3;
					end
				end else begin
					r.st.acc  = w8;
					r.st.pend = s.pend - 2'd1;
					if (s.pend == 2'd1) begin
						r.emit   = 1'b1;
						r.cp     = w8;
						r.st.acc = '0;
					end
				end
			end
			MODE_UTF16: begin
				if (s.pend == 2'd0) begin
					r.st.acc  = {24'd0, b};
					r.st.pend = 2'd1;
				end else begin
					r.st.acc  = '0;
					r.st.pend = 2'd0;
					if (s.held) begin
						r.emit    = 1'b1;
						r.cp      = pair;
						r.st.held = 1'b0;
						r.st.hi   = '0;
					end else if ((u & SUR_MASK) == SUR_HIGH) begin
						r.st.hi   = u[9:0];
						r.st.held = 1'b1;
					end else begin
						r.emit = 1'b1;
						r.cp   = {16'd0, u};
					end
				end
			end
			MODE_UTF32: begin
				if (s.pend == 2'd3) begin
					r.emit    = 1'b1;
					r.cp      = w32;
					r.st.acc  = '0;
					r.st.pend = 2'd0;
				end else begin
					r.st.acc  = w32;
					r.st.pend = s.pend + 2'd1;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/unicode_bom_sniff_decoder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// unicode_bom_sniff_decoder - byte stream to code points with BOM sniffing
// A byte waits in the input register until the 8-deep queue has room, then its results go in.
// Throughput: one byte a cycle unless byte_stall; results leave one a cycle unless char_stall.
// Reset clears mode, sniff buffer, decoder state and queue; a text end clears all but the queue.
// ----------------------------------------------------------------------------
module unicode_bom_sniff_decoder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  ubsd_pkg::in_word_t   byte_word,
	output logic                 char_valid,
	input  logic                 char_stall,
	output ubsd_pkg::out_word_t  char_word
);
	import ubsd_pkg::*;

	logic           valid_s1;
	in_word_t       word_s1;

	mode_t          mode_q, mode_d, new_mode;
	dstate_t        dec_q, dec_d;
	logic [7:0]     sniff_q [4];
	logic [7:0]     sniff_d [4];
	logic [2:0]     sniff_cnt_q, sniff_cnt_d;

	logic [7:0]     nb [4];
	logic [2:0]     c_new;
	dec_t           dec;

	mode_t          chain_mode;
	dstate_t        chain_st0;
	logic [7:0]     slot_byte [4];
	logic [3:0]     slot_en;
	feed_t          fr [4];
	dstate_t        chain [5];

	out_word_t      res [MAX_RES];
	logic [2:0]     n_res;
	logic [1:0]     end_st;

	out_word_t            fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]     fill_q;
	logic                 dispatch, accept, pop;

	assign accept     = byte_valid && !byte_stall;
	assign dispatch   = valid_s1 && (fill_q <= (FIFO_AW+1)'(FIFO_DEPTH - MAX_RES));
	assign byte_stall = valid_s1 && !dispatch;
	assign char_valid = (fill_q != '0);
	assign char_word  = fifo_q[rd_ptr_q];
	assign pop        = char_valid && !char_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (dispatch) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= byte_word;
		end
	end

	// mark detection on the held bytes plus the new one
	always_comb begin
		nb = sniff_q;
		nb[sniff_cnt_q[1:0]] = word_s1.in_byte;
		c_new = sniff_cnt_q + 3'd1;
		dec = decide(nb[0], nb[1], nb[2], nb[3], c_new, word_s1.in_last);
	end

	// up to four bytes go through the decoder: the replayed held bytes or the new word
	always_comb begin
		chain_mode = mode_q;
		chain_st0  = dec_q;
		new_mode   = mode_q;
		slot_byte  = nb;
		slot_en    = '0;
		if (mode_q == MODE_SNIFF) begin
			chain_st0 = '0;
			case (dec)
				DEC_REPLAY8: begin
					new_mode   = MODE_UTF8;
					chain_mode = MODE_UTF8;
					for (int i = 0; i < 4; i++)
						slot_en[i] = (3'(i) < c_new);
				end
				DEC_SKIP8: new_mode = MODE_UTF8;
				DEC_UTF16: begin
					new_mode   = MODE_UTF16;
					chain_mode = MODE_UTF16;
					for (int i = 2; i < 4; i++)
						slot_en[i] = (3'(i) < c_new);
				end
				DEC_UTF32: new_mode = MODE_UTF32;
				DEC_UNSUP: new_mode = MODE_UNSUP;
				default: ;
			endcase
		end else begin
			slot_byte[0] = word_s1.in_byte;
			slot_en[0]   = 1'b1;
		end
	end

	always_comb begin
		chain[0] = chain_st0;
		for (int i = 0; i < 4; i++) begin
			fr[i] = feed(chain_mode, chain[i], slot_byte[i]);
			chain[i+1] = slot_en[i] ? fr[i].st : chain[i];
		end
	end

	// pack results in order, then close the text if this is its last word
	always_comb begin
		n_res = '0;
		for (int k = 0; k < MAX_RES; k++)
			res[k] = '0;
		for (int i = 0; i < 4; i++) begin
			if (slot_en[i] && fr[i].emit) begin
				res[n_res[1:0]] = '{code_point: fr[i].cp, has_char: 1'b1,
					status: ST_OK, out_last: 1'b0};
				n_res = n_res + 3'd1;
			end
		end
		if (new_mode == MODE_UNSUP)
			end_st = ST_UNSUP;
		else if (chain[4].pend != 2'd0 || chain[4].held)
			end_st = ST_TRUNC;
		else
			end_st = ST_OK;
		if (word_s1.in_last) begin
			if (end_st == ST_OK && n_res != 3'd0) begin
				res[n_res[1:0] - 2'd1].out_last = 1'b1;
			end else if (n_res < 3'(MAX_RES)) begin
				res[n_res[1:0]] = '{code_point: 32'd0, has_char: 1'b0,
					status: end_st, out_last: 1'b1};
				n_res = n_res + 3'd1;
			end
		end
	end

	// next state
	always_comb begin
		mode_d      = mode_q;
		dec_d       = dec_q;
		sniff_d     = sniff_q;
		sniff_cnt_d = sniff_cnt_q;
		if (dispatch) begin
			if (word_s1.in_last) begin
				mode_d      = MODE_SNIFF;
				dec_d       = '0;
				sniff_d     = '{default: 8'd0};
				sniff_cnt_d = '0;
			end else begin
				mode_d = new_mode;
				dec_d  = chain[4];
				if (mode_q == MODE_SNIFF) begin
					if (new_mode == MODE_SNIFF) begin
						sniff_d     = nb;
						sniff_cnt_d = c_new;
					end else begin
						sniff_d     = '{default: 8'd0};
						sniff_cnt_d = '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_SNIFF;
			dec_q       <= '0;
			sniff_q     <= '{default: 8'd0};
			sniff_cnt_q <= '0;
		end else begin
			mode_q      <= mode_d;
			dec_q       <= dec_d;
			sniff_q     <= sniff_d;
			sniff_cnt_q <= sniff_cnt_d;
		end
	end

	// result queue: up to four words in, one out per cycle while char_stall is low
	always_ff @(posedge clk) begin
		if (dispatch) begin
			for (int k = 0; k < MAX_RES; k++) begin
				if (3'(k) < n_res)
					fifo_q[wr_ptr_q + FIFO_AW'(k)] <= res[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (dispatch)
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(n_res);
			if (pop)
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			fill_q <= fill_q + (dispatch ? (FIFO_AW+1)'(n_res) : '0)
				- (pop ? (FIFO_AW+1)'(1) : '0);
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= (FIFO_AW+1)'(FIFO_DEPTH))
		else $error("result queue overfilled");

	a_sniff_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_SNIFF |-> sniff_cnt_q < 3'd4)
		else $error("sniff buffer overrun");

	a_sniff_clear: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != MODE_SNIFF |-> sniff_cnt_q == 3'd0)
		else $error("sniff count left after decision");

	a_end_reset: assert property (@(posedge clk) disable iff (!arst_n)
		dispatch && word_s1.in_last |=> mode_q == MODE_SNIFF && dec_q == '0)
		else $error("state not cleared after last word");

	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		dispatch && word_s1.in_last |-> n_res != 3'd0)
		else $error("last word gave no result");

endmodule
`default_nettype wire
